@@ hw/rtl/ddwc_pkg.sv @@
`timescale 1ns / 1ps
package ddwc_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

	localparam logic [2:0] CFG_MODE = 3'd0;
	localparam logic [2:0] CFG_OFFSET = 3'd1;
	localparam logic [2:0] CFG_BASE = 3'd2;
	localparam logic [2:0] CFG_RADIUS = 3'd3;
	localparam logic [2:0] CFG_PERIOD = 3'd4;

	localparam logic [1:0] MODE_FBL = 2'd0;
	localparam logic [1:0] MODE_DIRECT = 2'd1;
	localparam logic [1:0] MODE_INTEG = 2'd2;

	typedef logic signed [63:0] div_num_t;
	typedef logic signed [64:0] div_quo_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0: return 32'h3243F6A8;
			5'd1: return 32'h1DAC6705;
			5'd2: return 32'h0FADBAFC;
			5'd3: return 32'h07F56EA6;
			5'd4: return 32'h03FEAB76;
			5'd5: return 32'h01FFD55B;
			5'd6: return 32'h00FFFAAA;
			5'd7: return 32'h007FFF55;
			5'd8: return 32'h003FFFEA;
			5'd9: return 32'h001FFFFD;
			5'd10: return 32'h000FFFFF;
			5'd11: return 32'h0007FFFF;
			5'd12: return 32'h0003FFFF;
			5'd13: return 32'h0001FFFF;
			5'd14: return 32'h0000FFFF;
			5'd15: return 32'h00007FFF;
			5'd16: return 32'h00003FFF;
			5'd17: return 32'h00001FFF;
			5'd18: return 32'h00000FFF;
			5'd19: return 32'h000007FF;
			5'd20: return 32'h000003FF;
			5'd21: return 32'h000001FF;
			5'd22: return 32'h000000FF;
			5'd23: return 32'h0000007F;
			5'd24: return 32'h0000003F;
			5'd25: return 32'h0000001F;
			5'd26: return 32'h0000000F;
			5'd27: return 32'h00000008;
			5'd28: return 32'h00000004;
			5'd29: return 32'h00000002;
			default: return 32'h0;
		endcase
	endfunction

endpackage

@@ hw/rtl/ddwc_div.sv @@
`timescale 1ns / 1ps
module ddwc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ddwc_pkg::div_num_t num,
	input  logic [30:0]       den,
	output logic              done,
	output ddwc_pkg::div_quo_t quo
);
	import ddwc_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [30:0] rem_q;
	logic [30:0] den_q;
	logic [63:0] q_q;
	logic        neg_q;
	logic [31:0] trial;
	logic        ge;

	assign trial = {rem_q, q_q[63]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[63];
			q_q <= num[63] ? (~num + 64'd1) : num;
			den_q <= (den == '0) ? 31'd1 : den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 31'(trial - {1'b0, den_q}) : trial[30:0];
			q_q <= {q_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quo = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

endmodule

@@ hw/rtl/diff_drive_wheel_command.sv @@
`timescale 1ns / 1ps
// channel | signals                          | beat when
// in      | in_valid, in_stall, u1 u2 heading | in_valid && !in_stall
// out     | out_valid, out_stall, rates, flag | out_valid && !out_stall
// cfg     | cfg_valid, cfg_ready, index, data | cfg_valid && cfg_ready
// Mode 0: 30 CORDIC steps, four multiplies for the rotated command, the base multiply
// and three divides on the shared divider; the next input beat waits for the result.
// Modes 1 and 3: base multiply and two divides; mode 2 first adds the integrator step.
// Reset clears the integrator and loads register defaults.
// in_stall is high while an item is in work; a stalled result holds the next finish.
module diff_drive_wheel_command #(
	parameter int DATA_WIDTH = 32,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] command_first,
	input  logic signed [31:0] command_second,
	input  logic signed [14:0] heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] right_wheel_rate,
	output logic signed [31:0] left_wheel_rate,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import ddwc_pkg::*;

	localparam int SAT_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam int TF = ANGLE_WIDTH - 2;
	localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (SAT_BITS - 1)) - 66'sd1;
	localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;
	localparam logic signed [33:0] RND = 34'sd1 <<< (29 - TF);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CORD = 4'd1;
	localparam logic [3:0] S_RND = 4'd2;
	localparam logic [3:0] S_M1 = 4'd3;
	localparam logic [3:0] S_M2 = 4'd4;
	localparam logic [3:0] S_M3 = 4'd5;
	localparam logic [3:0] S_M4 = 4'd6;
	localparam logic [3:0] S_DW = 4'd7;
	localparam logic [3:0] S_INT = 4'd8;
	localparam logic [3:0] S_H = 4'd9;
	localparam logic [3:0] S_DR = 4'd10;
	localparam logic [3:0] S_DL = 4'd11;
	localparam logic [3:0] S_OUT = 4'd12;

	function automatic logic signed [65:0] clip(input logic signed [65:0] a);
		if (a > SAT_HI)
			return SAT_HI;
		if (a < SAT_LO)
			return SAT_LO;
		return a;
	endfunction

	logic [3:0]  state_q;
	logic [1:0]  mode_q;
	logic [30:0] offset_q, base_q, radius_q, period_q;
	logic signed [31:0] integ_q;
	logic signed [31:0] u1_q, u2_q, v_q, w_q, right_q, left_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic        neg_q;
	logic [4:0]  step_q;
	logic signed [32:0] mul_a_q, mul_b_q;
	logic signed [65:0] prod, acc_q, half_q;
	logic        flag_q;
	logic        out_valid_q;
	logic signed [31:0] out_r_q, out_l_q;
	logic        out_f_q;

	logic        div_start, div_done;
	div_num_t    div_num;
	div_quo_t    div_quo;
	logic [30:0] div_den;

	logic        accept;
	logic signed [33:0] z0, dx, dy, atn;
	logic signed [65:0] vr, nw, incr, isum, isat, w2, qx, qc, vs;
	logic signed [33:0] cr, sr;

	assign prod = mul_a_q * mul_b_q;
	assign accept = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign cfg_ready = 1'b1;

	always_comb begin
		z0 = 34'(heading) <<< 18;
		dx = y_q >>> step_q;
		dy = x_q >>> step_q;
		atn = 34'($signed({2'b00, atan_q30(step_q)}));
		cr = ((neg_q ? -x_q : x_q) + RND) >>> (30 - TF);
		sr = ((neg_q ? -y_q : y_q) + RND) >>> (30 - TF);
		vr = (acc_q + prod) >>> TF;
		nw = (acc_q - prod) >>> TF;
		incr = prod >>> 16;
		isum = 66'(integ_q) + incr;
		isat = clip(isum);
		w2 = clip(66'(u2_q));
		qx = 66'(div_quo);
		qc = clip(qx);
		vs = 66'(v_q) <<< 16;
		div_start = 1'b0;
		div_num = '0;
		case (state_q)
			S_M4: begin
				div_start = 1'b1;
				div_num = 64'(nw <<< 16);
			end
			S_H: begin
				div_start = 1'b1;
				div_num = 64'(vs + (prod >>> 1));
			end
			S_DR: begin
				div_start = div_done;
				div_num = 64'(vs - half_q);
			end
			default: ;
		endcase
		div_den = (state_q == S_M4) ? offset_q : radius_q;
	end

	ddwc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= MODE_FBL;
			offset_q <= 31'd6554;
			base_q <= 31'd22938;
			radius_q <= 31'd6554;
			period_q <= 31'd3277;
			integ_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[1:0];
					CFG_OFFSET: offset_q <= cfg_data[30:0];
					CFG_BASE: base_q <= cfg_data[30:0];
					CFG_RADIUS: radius_q <= cfg_data[30:0];
					CFG_PERIOD: period_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (state_q == S_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode_q == MODE_FBL)
							state_q <= S_CORD;
						else if (mode_q == MODE_INTEG)
							state_q <= S_INT;
						else
							state_q <= S_H;
					end
				end
				S_CORD: if (step_q == 5'(CORDIC_STEPS - 1)) state_q <= S_RND;
				S_RND: state_q <= S_M1;
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_DW;
				S_DW: if (div_done) state_q <= S_H;
				S_INT: begin
					integ_q <= 32'(isat);
					state_q <= S_H;
				end
				S_H: state_q <= S_DR;
				S_DR: if (div_done) state_q <= S_DL;
				S_DL: if (div_done) state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || !out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				u1_q <= command_first;
				u2_q <= command_second;
				step_q <= '0;
				neg_q <= (z0 > HALF_PI_Q30) || (z0 < -HALF_PI_Q30);
				x_q <= CORDIC_GAIN;
				y_q <= '0;
				if (z0 > HALF_PI_Q30)
					z_q <= z0 - PI_Q30;
				else if (z0 < -HALF_PI_Q30)
					z_q <= z0 + PI_Q30;
				else
					z_q <= z0;
				w_q <= 32'(clip(66'(command_second)));
				if (mode_q == MODE_INTEG) begin
					mul_a_q <= $signed({2'b00, period_q});
					mul_b_q <= 33'(command_first);
				end else begin
					mul_a_q <= $signed({2'b00, base_q});
					mul_b_q <= 33'(clip(66'(command_second)));
				end
				if (mode_q != MODE_FBL && mode_q != MODE_INTEG) begin
					v_q <= 32'(clip(66'(command_first)));
					flag_q <= (clip(66'(command_first)) != 66'(command_first))
						|| (clip(66'(command_second)) != 66'(command_second));
				end else begin
					v_q <= command_first;
					flag_q <= 1'b0;
				end
			end
			S_CORD: begin
				step_q <= step_q + 5'd1;
				if (!z_q[33]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atn;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atn;
				end
			end
			S_RND: begin
				x_q <= cr;
				y_q <= sr;
				mul_a_q <= 33'(cr);
				mul_b_q <= 33'(u1_q);
			end
			S_M1: begin
				acc_q <= prod;
				mul_a_q <= 33'(y_q);
				mul_b_q <= 33'(u2_q);
			end
			S_M2: begin
				v_q <= 32'(clip(vr));
				if (clip(vr) != vr)
					flag_q <= 1'b1;
				mul_a_q <= 33'(x_q);
				mul_b_q <= 33'(u2_q);
			end
			S_M3: begin
				acc_q <= prod;
				mul_a_q <= 33'(y_q);
				mul_b_q <= 33'(u1_q);
			end
			S_DW: begin
				if (div_done) begin
					w_q <= 32'(qc);
					if (qc != qx)
						flag_q <= 1'b1;
					mul_a_q <= $signed({2'b00, base_q});
					mul_b_q <= 33'(qc);
				end
			end
			S_INT: begin
				v_q <= 32'(isat);
				w_q <= 32'(w2);
				if ((isat != isum) || (w2 != 66'(u2_q)))
					flag_q <= 1'b1;
				mul_a_q <= $signed({2'b00, base_q});
				mul_b_q <= 33'(w2);
			end
			S_H: half_q <= prod >>> 1;
			S_DR: begin
				if (div_done) begin
					right_q <= 32'(qc);
					if (qc != qx)
						flag_q <= 1'b1;
				end
			end
			S_DL: begin
				if (div_done) begin
					left_q <= 32'(qc);
					if (qc != qx)
						flag_q <= 1'b1;
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_r_q <= right_q;
					out_l_q <= left_q;
					out_f_q <= flag_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign right_wheel_rate = out_r_q;
	assign left_wheel_rate = out_l_q;
	assign saturated = out_f_q;

endmodule

@@ hw/rtl/ddwc_checker.sv @@
`timescale 1ns / 1ps
module ddwc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] right_wheel_rate,
	input logic signed [31:0] left_wheel_rate,
	input logic               saturated,
	input logic               cfg_valid,
	input logic               cfg_ready
);
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("no stall after input beat");
	a_out_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall)) else $error("result without work");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(right_wheel_rate)
		&& $stable(left_wheel_rate) && $stable(saturated))) else $error("stalled result moved");
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready) else $error("cfg not ready");
endmodule

bind diff_drive_wheel_command ddwc_checker u_ddwc_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import ddwc_pkg::*;

	typedef struct {
		logic signed [31:0] u1;
		logic signed [31:0] u2;
		logic signed [14:0] hd;
	} cmd_t;

	typedef struct {
		logic signed [31:0] right;
		logic signed [31:0] left;
		logic               sat;
	} rate_t;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	localparam int LIMIT = 2000000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] command_first = 0;
	logic signed [31:0] command_second = 0;
	logic signed [14:0] heading = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] right_wheel_rate;
	logic signed [31:0] left_wheel_rate;
	logic saturated;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	diff_drive_wheel_command DUT (.*);

	cmd_t cmd_q[$];
	rate_t rate_q[$];
	int errors = 0;
	int in_gap = 0;
	int out_gap = 0;
	bit calm = 0;
	bit started = 0;
	bit in_beat = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_sat = 0;
	longint cycles = 0;

	logic [1:0] m_mode;
	longint m_off, m_base, m_rad, m_per, m_integ;
	longint atan_tab[30] = '{
		'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
		'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
		'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
		'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
		'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint clip(longint v, ref bit flag);
		if (v > SAT_HI) begin
			flag = 1;
			return SAT_HI;
		end
		if (v < SAT_LO) begin
			flag = 1;
			return SAT_LO;
		end
		return v;
	endfunction

	task automatic rotate_heading(longint ang, output longint c, output longint s);
		longint z, x, y, dx, dy;
		bit neg;
		z = ang * 262144;
		x = CORDIC_GAIN;
		y = 0;
		neg = 0;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			neg = 1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			neg = 1;
		end
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_tab[i];
			end else begin
				x += dx;
				y -= dy;
				z += atan_tab[i];
			end
		end
		if (neg) begin
			x = -x;
			y = -y;
		end
		c = (x + (64'sd1 << 15)) >>> 16;
		s = (y + (64'sd1 << 15)) >>> 16;
	endtask

	task automatic predict_rates(cmd_t cmd);
		longint u1, u2, v, w, c, s, nw, b, rad, half, inc;
		bit flag;
		rate_t r;
		u1 = cmd.u1;
		u2 = cmd.u2;
		flag = 0;
		rad = m_rad ? m_rad : 1;
		if (m_mode == MODE_FBL) begin
			b = m_off ? m_off : 1;
			rotate_heading(longint'(cmd.hd), c, s);
			v = clip((c * u1 + s * u2) >>> 14, flag);
			nw = (c * u2 - s * u1) >>> 14;
			w = clip((nw * 65536) / b, flag);
		end else if (m_mode == MODE_INTEG) begin
			inc = (m_per * u1) >>> 16;
			m_integ = clip(m_integ + inc, flag);
			v = m_integ;
			w = clip(u2, flag);
		end else begin
			v = clip(u1, flag);
			w = clip(u2, flag);
		end
		half = (m_base * w) >>> 1;
		r.right = clip((v * 65536 + half) / rad, flag);
		r.left = clip((v * 65536 - half) / rad, flag);
		r.sat = flag;
		rate_q.push_back(r);
	endtask

	always @(negedge clk) begin
		if (arst_n && started) begin
			if (!in_valid || in_beat) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 0;
				end else if (cmd_q.size() > 0) begin
					command_first <= cmd_q[0].u1;
					command_second <= cmd_q[0].u2;
					heading <= cmd_q[0].hd;
					in_valid <= 1;
					cmd_q.pop_front();
					if (!calm && $urandom_range(0, 5) == 0)
						in_gap <= $urandom_range(1, 19);
				end else begin
					in_valid <= 0;
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1;
			end else begin
				out_stall <= 0;
				if (!calm && $urandom_range(0, 5) == 0)
					out_gap <= $urandom_range(1, 19);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			in_beat <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				cmd_t cmd;
				cmd.u1 = command_first;
				cmd.u2 = command_second;
				cmd.hd = heading;
				predict_rates(cmd);
				n_sent <= n_sent + 1;
			end
			if (out_valid && !out_stall) begin
				if (rate_q.size() == 0) begin
					$error("unexpected result beat");
					errors++;
				end else begin
					rate_t e;
					e = rate_q.pop_front();
					n_checked <= n_checked + 1;
					if (e.sat)
						n_sat <= n_sat + 1;
					if (right_wheel_rate !== e.right) begin
						$error("right_wheel_rate exp %0d got %0d", e.right, right_wheel_rate);
						errors++;
					end
					if (left_wheel_rate !== e.left) begin
						$error("left_wheel_rate exp %0d got %0d", e.left, left_wheel_rate);
						errors++;
					end
					if (saturated !== e.sat) begin
						$error("saturated exp %0d got %0d", e.sat, saturated);
						errors++;
					end
				end
			end
			if (cycles > LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_MODE: m_mode = val[1:0];
			CFG_OFFSET: m_off = val[30:0];
			CFG_BASE: m_base = val[30:0];
			CFG_RADIUS: m_rad = val[30:0];
			CFG_PERIOD: m_per = val[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		while (cmd_q.size() > 0 || in_valid || rate_q.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(0, 'h3FFFF) - 'h1FFFF;
			3: return $urandom_range(0, 'h3FFFFFF) - 'h1FFFFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.u1 = rand_word();
		c.u2 = rand_word();
		c.hd = $urandom_range(0, 3) == 0 ? 15'($urandom) : 15'($urandom_range(0, 25736) - 12868);
		return c;
	endfunction

	function automatic cmd_t mk(logic [31:0] a, logic [31:0] b, logic [14:0] h);
		cmd_t c;
		c.u1 = a;
		c.u2 = b;
		c.hd = h;
		return c;
	endfunction

	function automatic logic [31:0] rand_param();
		case ($urandom_range(0, 4))
			0: return 32'h7FFFFFFF;
			1: return $urandom_range(0, 1);
			2: return $urandom_range(1000, 200000);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		m_mode = MODE_FBL;
		m_off = 6554;
		m_base = 22938;
		m_rad = 6554;
		m_per = 3277;
		m_integ = 0;
		repeat (7) @(posedge clk);
		#1 arst_n = 1;
		started = 1;
		cmd_q.push_back(mk(0, 0, 0));
		cmd_q.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 15'sd12868));
		cmd_q.push_back(mk(32'h80000000, 32'h80000000, -15'sd12868));
		cmd_q.push_back(mk(32'h00010000, 32'hFFFF0000, 15'sd6434));
		cmd_q.push_back(mk(32'h00010000, 32'h00010000, 15'h3FFF));
		cmd_q.push_back(mk(32'h00010000, 32'h00020000, 15'h4000));
		cmd_q.push_back(mk(32'hFFFFFFFF, 32'h00000001, 15'sd6500));
		drain();
		for (int p = 0; p < 5; p++) begin
			write_reg(CFG_MODE, p);
			write_reg(CFG_OFFSET, p == 1 ? 0 : p == 2 ? 32'h7FFFFFFF : 65536);
			write_reg(CFG_BASE, p == 3 ? 0 : p == 4 ? 32'h7FFFFFFF : 22938);
			write_reg(CFG_RADIUS, p == 0 ? 0 : p == 2 ? 32'h7FFFFFFF : 6554);
			write_reg(CFG_PERIOD, p == 2 ? 32'h7FFFFFFF : 3277);
			cmd_q.push_back(mk(32'h7FFFFFFF, 32'h80000000, 15'sd12868));
			cmd_q.push_back(mk(32'h80000000, 32'h7FFFFFFF, 15'h4000));
			cmd_q.push_back(mk(32'h00008000, 32'hFFFF8000, 15'sd100));
			drain();
		end
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(CFG_MODE, ph < 11 ? $urandom_range(0, 3) : MODE_INTEG);
			write_reg(CFG_OFFSET, rand_param());
			write_reg(CFG_BASE, rand_param());
			write_reg(CFG_RADIUS, rand_param());
			write_reg(CFG_PERIOD, rand_param());
			calm = ph == 11;
			for (int i = 0; i < 50; i++)
				cmd_q.push_back(rand_cmd());
			drain();
		end
		$display("sent %0d commands, checked %0d results, %0d saturated",
			n_sent, n_checked, n_sat);
		$display("covered all four modes and extreme register settings");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
